/* rtl/tgd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgd_pkg: shared types, constants and microcode for the group deframer
// Holds the group store geometry, result status codes, register indexes,
// the control word layout and the microprogram that drives the datapath.
// ----------------------------------------------------------------------------
package tgd_pkg;

	localparam int GROUP_BYTES = 32;
	localparam int IDX_W       = $clog2(GROUP_BYTES);
	localparam logic [IDX_W-1:0] FILL_MAX = IDX_W'(GROUP_BYTES - 1);

	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 8;
	localparam int SUM_W    = 6;

	localparam logic [BYTE_W-1:0] SUM_BIAS  = 8'h20;
	localparam logic [BYTE_W-1:0] RST_START = 8'h0A;
	localparam logic [BYTE_W-1:0] RST_END   = 8'h0D;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_PAYLOAD = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADSUM  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END   = 8'd1;

	// sequencer steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
	localparam logic [STEP_W-1:0] S_LEN      = 4'd1;
	localparam logic [STEP_W-1:0] S_SUM_RD   = 4'd2;
	localparam logic [STEP_W-1:0] S_SUM_ACC  = 4'd3;
	localparam logic [STEP_W-1:0] S_CHK_RD   = 4'd4;
	localparam logic [STEP_W-1:0] S_CHK      = 4'd5;
	localparam logic [STEP_W-1:0] S_EMIT_BAD = 4'd6;
	localparam logic [STEP_W-1:0] S_EMPTY    = 4'd7;
	localparam logic [STEP_W-1:0] S_EMIT_EMP = 4'd8;
	localparam logic [STEP_W-1:0] S_PAY_RD   = 4'd9;
	localparam logic [STEP_W-1:0] S_PAY_LD   = 4'd10;

	// jump conditions
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] C_ALWAYS   = 3'd0;
	localparam logic [COND_W-1:0] C_CLOSE    = 3'd1;
	localparam logic [COND_W-1:0] C_SHORT    = 3'd2;
	localparam logic [COND_W-1:0] C_PTR_END  = 3'd3;
	localparam logic [COND_W-1:0] C_BAD      = 3'd4;
	localparam logic [COND_W-1:0] C_PLEN0    = 3'd5;
	localparam logic [COND_W-1:0] C_PAY_LAST = 3'd6;

	typedef struct packed {
		logic                in_rdy;
		logic                rd_en;
		logic                rd_last;
		logic                acc_clr;
		logic                acc_add;
		logic                ptr_clr;
		logic                ptr_inc;
		logic                out_load;
		logic [STATUS_W-1:0] out_st;
		logic [COND_W-1:0]   cond;
		logic [STEP_W-1:0]   jmp;
		logic [STEP_W-1:0]   nxt;
	} ctrl_word_t;

	typedef struct packed {
		logic close;
		logic short_grp;
		logic ptr_end;
		logic bad;
		logic plen0;
		logic pay_last;
		logic out_busy;
	} dp_status_t;

	// microprogram: cond true takes jmp, otherwise nxt
	function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
		ctrl_word_t cw;
		cw        = '0;
		cw.out_st = ST_PAYLOAD;
		cw.cond   = C_ALWAYS;
		cw.jmp    = S_IDLE;
		cw.nxt    = S_IDLE;
		case (step)
			S_IDLE: begin
				cw.in_rdy = 1'b1;
				cw.cond   = C_CLOSE;
				cw.jmp    = S_LEN;
				cw.nxt    = S_IDLE;
			end
			S_LEN: begin
				cw.ptr_clr = 1'b1;
				cw.acc_clr = 1'b1;
				cw.cond    = C_SHORT;
				cw.jmp     = S_IDLE;
				cw.nxt     = S_SUM_RD;
			end
			S_SUM_RD: begin
				cw.rd_en = 1'b1;
				cw.cond  = C_PTR_END;
				cw.jmp   = S_CHK_RD;
				cw.nxt   = S_SUM_ACC;
			end
			S_SUM_ACC: begin
				cw.acc_add = 1'b1;
				cw.ptr_inc = 1'b1;
				cw.jmp     = S_SUM_RD;
			end
			S_CHK_RD: begin
				cw.rd_en   = 1'b1;
				cw.rd_last = 1'b1;
				cw.ptr_clr = 1'b1;
				cw.jmp     = S_CHK;
			end
			S_CHK: begin
				cw.cond = C_BAD;
				cw.jmp  = S_EMIT_BAD;
				cw.nxt  = S_EMPTY;
			end
			S_EMIT_BAD: begin
				cw.out_load = 1'b1;
				cw.out_st   = ST_BADSUM;
				cw.jmp      = S_IDLE;
			end
			S_EMPTY: begin
				cw.cond = C_PLEN0;
				cw.jmp  = S_EMIT_EMP;
				cw.nxt  = S_PAY_RD;
			end
			S_EMIT_EMP: begin
				cw.out_load = 1'b1;
				cw.out_st   = ST_EMPTY;
				cw.jmp      = S_IDLE;
			end
			S_PAY_RD: begin
				cw.rd_en = 1'b1;
				cw.jmp   = S_PAY_LD;
			end
			S_PAY_LD: begin
				cw.out_load = 1'b1;
				cw.out_st   = ST_PAYLOAD;
				cw.ptr_inc  = 1'b1;
				cw.cond     = C_PAY_LAST;
				cw.jmp      = S_IDLE;
				cw.nxt      = S_PAY_RD;
			end
			default: begin
				cw.jmp = S_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

/* rtl/tgd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgd_if: channel interfaces of the group deframer
// Received byte channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface tgd_rx_if;
	logic                       valid;
	logic                       ready;
	logic [tgd_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface tgd_res_if;
	logic                         valid;
	logic                         ready;
	logic [tgd_pkg::BYTE_W-1:0]   out_byte;
	logic [tgd_pkg::STATUS_W-1:0] status;
	logic                         last;

	modport source (output valid, output out_byte, output status, output last, input ready);
	modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

interface tgd_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [tgd_pkg::CFG_IDX_W-1:0] index;
	logic [tgd_pkg::BYTE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/tgd_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgd_seq: microcode sequencer
// Step counter, control word lookup and conditional jumps; holds the step
// while a result load waits for the output register.
// ----------------------------------------------------------------------------
module tgd_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tgd_pkg::dp_status_t          stat,
	output tgd_pkg::ctrl_word_t          cw,
	output logic [tgd_pkg::STEP_W-1:0]   step
);

	logic [tgd_pkg::STEP_W-1:0] step_q;
	logic [tgd_pkg::STEP_W-1:0] step_nx;
	tgd_pkg::ctrl_word_t        cw_raw;
	logic                       stall;
	logic                       take;

	assign cw_raw = tgd_pkg::ucode(step_q);
	assign stall  = cw_raw.out_load & stat.out_busy;
	assign cw     = stall ? '0 : cw_raw;
	assign step   = step_q;

	always_comb begin
		case (cw_raw.cond)
			tgd_pkg::C_ALWAYS:   take = 1'b1;
			tgd_pkg::C_CLOSE:    take = stat.close;
			tgd_pkg::C_SHORT:    take = stat.short_grp;
			tgd_pkg::C_PTR_END:  take = stat.ptr_end;
			tgd_pkg::C_BAD:      take = stat.bad;
			tgd_pkg::C_PLEN0:    take = stat.plen0;
			tgd_pkg::C_PAY_LAST: take = stat.pay_last;
			default:             take = 1'b1;
		endcase
	end

	always_comb begin
		if (stall) begin
			step_nx = step_q;
		end else if (take) begin
			step_nx = cw_raw.jmp;
		end else begin
			step_nx = cw_raw.nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= tgd_pkg::S_IDLE;
		end else begin
			step_q <= step_nx;
		end
	end

endmodule

/* rtl/tgd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgd_datapath: group store, checksum accumulator and result register
// Captures bytes, keeps the configuration registers and carries out the
// actions named by the control word.
// ----------------------------------------------------------------------------
module tgd_datapath (
	input  logic                clk,
	input  logic                arst_n,
	tgd_rx_if.sink              rx,
	tgd_res_if.source           res,
	tgd_cfg_if.sink             cfg,
	input  tgd_pkg::ctrl_word_t cw,
	output tgd_pkg::dp_status_t stat
);

	logic [tgd_pkg::BYTE_W-1:0]   start_q;
	logic [tgd_pkg::BYTE_W-1:0]   end_q;
	logic                         receiving_q;
	logic [tgd_pkg::IDX_W-1:0]    fill_q;
	logic [tgd_pkg::IDX_W-1:0]    ptr_q;
	logic [tgd_pkg::SUM_W-1:0]    acc_q;
	logic [tgd_pkg::BYTE_W-1:0]   rdata_q;
	logic [tgd_pkg::BYTE_W-1:0]   mem_q [tgd_pkg::GROUP_BYTES];
	logic                         ovalid_q;
	logic [tgd_pkg::BYTE_W-1:0]   obyte_q;
	logic [tgd_pkg::STATUS_W-1:0] ostatus_q;
	logic                         olast_q;

	logic                         rx_acc;
	logic                         is_end;
	logic                         store_en;
	logic [tgd_pkg::IDX_W-1:0]    plen;
	logic [tgd_pkg::IDX_W-1:0]    rd_addr;
	logic [tgd_pkg::BYTE_W-1:0]   check;

	assign rx.ready  = cw.in_rdy;
	assign cfg.ready = 1'b1;
	assign rx_acc    = rx.valid & rx.ready;
	assign is_end    = (rx.rx_byte == end_q);
	assign store_en  = rx_acc & receiving_q & ~is_end & (fill_q < tgd_pkg::FILL_MAX);

	assign plen    = fill_q - tgd_pkg::IDX_W'(2);
	assign rd_addr = cw.rd_last ? (fill_q - tgd_pkg::IDX_W'(1)) : ptr_q;
	assign check   = {2'b00, acc_q} + tgd_pkg::SUM_BIAS;

	assign stat.close     = rx_acc & receiving_q & is_end;
	assign stat.short_grp = (fill_q < tgd_pkg::IDX_W'(2));
	assign stat.ptr_end   = (ptr_q == plen);
	assign stat.bad       = (rdata_q != check);
	assign stat.plen0     = (plen == '0);
	assign stat.pay_last  = ((ptr_q + tgd_pkg::IDX_W'(1)) == plen);
	assign stat.out_busy  = ovalid_q & ~res.ready;

	assign res.valid    = ovalid_q;
	assign res.out_byte = obyte_q;
	assign res.status   = ostatus_q;
	assign res.last     = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= tgd_pkg::RST_START;
			end_q   <= tgd_pkg::RST_END;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				tgd_pkg::REG_START: start_q <= cfg.data;
				tgd_pkg::REG_END:   end_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// group framing and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			fill_q      <= '0;
		end else if (rx_acc) begin
			if (!receiving_q) begin
				if (rx.rx_byte == start_q) begin
					fill_q      <= '0;
					receiving_q <= 1'b1;
				end
			end else if (is_end) begin
				receiving_q <= 1'b0;
			end else if (fill_q < tgd_pkg::FILL_MAX) begin
				fill_q <= fill_q + tgd_pkg::IDX_W'(1);
			end else begin
				// overflow: drop the group
				fill_q      <= '0;
				receiving_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			mem_q[fill_q] <= rx.rx_byte;
		end
		if (cw.rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			acc_q <= '0;
		end else begin
			if (cw.ptr_clr) begin
				ptr_q <= '0;
			end else if (cw.ptr_inc) begin
				ptr_q <= ptr_q + tgd_pkg::IDX_W'(1);
			end
			if (cw.acc_clr) begin
				acc_q <= '0;
			end else if (cw.acc_add) begin
				acc_q <= acc_q + rdata_q[tgd_pkg::SUM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cw.out_load) begin
			ovalid_q <= 1'b1;
		end else if (res.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.out_load) begin
			obyte_q   <= (cw.out_st == tgd_pkg::ST_PAYLOAD) ? rdata_q : '0;
			ostatus_q <= cw.out_st;
			olast_q   <= (cw.out_st != tgd_pkg::ST_PAYLOAD) | stat.pay_last;
		end
	end

endmodule

/* rtl/teleinfo_group_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teleinfo_group_deframer: meter link group deframer with checksum check
// Frames groups between start and end bytes, verifies the six-bit checksum
// and releases the payload bytes or a single status result.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                     | transaction when
//  --------+-----+-----------------------------+---------------------------
//  rx      | in  | rx_byte[7:0]                | rx.valid & rx.ready
//  res     | out | out_byte[7:0] status[1:0]   | res.valid & res.ready
//          |     | last                        |
//  cfg     | in  | index[7:0] data[7:0]        | cfg.valid & cfg.ready
//
// Sequence: a byte that does not close a group leaves rx.ready high. A
// closing byte with fewer than two bytes held drops rx.ready for the S_LEN
// step only. With n bytes held (payload p = n - 2) the checksum walk reads
// and adds the first p bytes, then reads and compares the checksum byte, and
// emits a bad-checksum or empty-payload status or releases the p payload
// bytes. The group store has a single read port; each read is its own step.
// Reset: arst_n clears framing, sequencer and output valid; registers return
// to line feed / carriage return. Stalls: a held result in the output
// register freezes the sequencer only at its next load step.
//
module teleinfo_group_deframer (
	input logic       clk,
	input logic       arst_n,
	tgd_rx_if.sink    rx,
	tgd_res_if.source res,
	tgd_cfg_if.sink   cfg
);

	tgd_pkg::ctrl_word_t        cw;
	tgd_pkg::dp_status_t        stat;
	logic [tgd_pkg::STEP_W-1:0] step;

	// step counter and microprogram
	tgd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cw     (cw),
		.step   (step)
	);

	// store, accumulator and output register
	tgd_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.res    (res),
		.cfg    (cfg),
		.cw     (cw),
		.stat   (stat)
	);

	// never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cw.out_load |-> (!res.valid || res.ready))
		else $error("result register overwritten while held");

	// a closing byte always starts the close program
	a_close_jumps: assert property (@(posedge clk) disable iff (!arst_n)
		stat.close |=> (step == tgd_pkg::S_LEN))
		else $error("close transaction did not start checksum program");

	// hold off input while the close program runs
	a_no_rx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(step != tgd_pkg::S_IDLE) |-> !rx.ready)
		else $error("input accepted outside idle step");

	// status-only results always close the run
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.status != tgd_pkg::ST_PAYLOAD)) |-> res.last)
		else $error("status result without last");

endmodule
